// ----- rtl/mtrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtrb_pkg
// Types and constants shared by the multichannel transmit ring buffer.
// ----------------------------------------------------------------------------
package mtrb_pkg;

    // Stream widths. Input tdata: data_byte, clear_to_send, rx_fifo_empty,
    // tx_fifo_full. Input tuser: action, channel. Output tdata: status,
    // tx_valid, tx_byte.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CHAN_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;

    localparam logic ACT_SAVE = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_TXFULL   = 3'd3,
        ST_NOTCLEAR = 3'd4,
        ST_BADCHAN  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RDWAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_read;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic send_hit;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/mtrb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtrb_ram
// Generic single-port RAM with a registered read that holds between reads.
// ----------------------------------------------------------------------------
module mtrb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/mtrb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtrb_ctrl
// Sequencer: takes one transaction, evaluates it, waits for queue read data.
// ----------------------------------------------------------------------------
module mtrb_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire mtrb_pkg::t_dp_status   i_status,
    output mtrb_pkg::t_ctrl_cmd         o_cmd
);

    mtrb_pkg::t_state r_state;
    mtrb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            mtrb_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = mtrb_pkg::S_EVAL;
                end
            end
            mtrb_pkg::S_EVAL: begin
                // Side effects happen only once the result slot can take a value.
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.send_hit ? mtrb_pkg::S_RDWAIT : mtrb_pkg::S_IDLE;
                end
            end
            mtrb_pkg::S_RDWAIT: begin
                o_cmd.load_read = 1'b1;
                n_state         = mtrb_pkg::S_IDLE;
            end
            default: begin
                n_state = mtrb_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/mtrb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtrb_datapath
// Item register, per-channel pointers, queue RAM and the result register.
// ----------------------------------------------------------------------------
module mtrb_datapath #(
    parameter int QUEUE_DEPTH  = 256,
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [mtrb_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  wire logic [mtrb_pkg::S_TUSER_W-1:0]     i_s_tuser,
    input  wire logic                               i_m_tready,
    input  wire mtrb_pkg::t_ctrl_cmd                i_cmd,
    output mtrb_pkg::t_dp_status                    o_status,
    output logic                                    o_m_tvalid,
    output logic [mtrb_pkg::M_TDATA_W-1:0]          o_m_tdata
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);
    localparam logic [PTR_W:0]   DEPTH_V  = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [mtrb_pkg::CHAN_W:0] NUM_CH_V = (mtrb_pkg::CHAN_W + 1)'(NUM_CHANNELS);
    localparam int PAD_W = mtrb_pkg::M_TDATA_W - mtrb_pkg::STATUS_W - 1 - mtrb_pkg::BYTE_W;

    // Latched transaction.
    logic                          r_action;
    logic [mtrb_pkg::CHAN_W-1:0]   r_chan;
    logic [mtrb_pkg::BYTE_W-1:0]   r_data;
    logic                          r_cts;
    logic                          r_rxfe;
    logic                          r_txff;

    logic [PTR_W-1:0] r_rp [NUM_CHANNELS];
    logic [PTR_W-1:0] r_wp [NUM_CHANNELS];

    logic                          r_out_valid;
    mtrb_pkg::t_status             r_out_status;
    logic                          r_out_txv;
    logic [mtrb_pkg::BYTE_W-1:0]   r_out_byte;

    logic [CH_W-1:0]               idx;
    logic [PTR_W-1:0]              rp_cur;
    logic [PTR_W-1:0]              wp_cur;
    logic [PTR_W-1:0]              rp_next;
    logic [PTR_W-1:0]              wp_next;
    logic                          chan_ok;
    logic                          is_full;
    logic                          is_empty;
    logic                          save_hit;
    logic                          send_hit;
    mtrb_pkg::t_status             eval_status;
    logic [ADDR_W-1:0]             mem_addr;
    logic [mtrb_pkg::BYTE_W-1:0]   mem_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_data   <= i_s_tdata[7:0];
            r_cts    <= i_s_tdata[8];
            r_rxfe   <= i_s_tdata[9];
            r_txff   <= i_s_tdata[10];
            r_action <= i_s_tuser[0];
            r_chan   <= i_s_tuser[2:1];
        end
    end

    always_comb begin
        idx      = r_chan[CH_W-1:0];
        rp_cur   = r_rp[idx];
        wp_cur   = r_wp[idx];
        rp_next  = (rp_cur == LAST_PTR) ? '0 : rp_cur + ONE_PTR;
        wp_next  = (wp_cur == LAST_PTR) ? '0 : wp_cur + ONE_PTR;
        chan_ok  = {1'b0, r_chan} < NUM_CH_V;
        is_full  = (wp_next == rp_cur);
        is_empty = (rp_cur == wp_cur);
        save_hit = 1'b0;
        send_hit = 1'b0;
        if (!chan_ok) begin
            eval_status = mtrb_pkg::ST_BADCHAN;
        end else if (r_action == mtrb_pkg::ACT_SAVE) begin
            if (is_full) begin
                eval_status = mtrb_pkg::ST_FULL;
            end else begin
                eval_status = mtrb_pkg::ST_DONE;
                save_hit    = 1'b1;
            end
        end else if (is_empty) begin
            eval_status = mtrb_pkg::ST_EMPTY;
        end else if ((r_chan == '0) && (!r_cts || !r_rxfe)) begin
            // Channel 0 also needs clear-to-send and a drained receive FIFO.
            eval_status = mtrb_pkg::ST_NOTCLEAR;
        end else if (r_txff) begin
            eval_status = mtrb_pkg::ST_TXFULL;
        end else begin
            eval_status = mtrb_pkg::ST_DONE;
            send_hit    = 1'b1;
        end
        mem_addr = ADDR_W'(r_chan) * ADDR_W'(QUEUE_DEPTH)
                 + ADDR_W'((r_action == mtrb_pkg::ACT_SEND) ? rp_cur : wp_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_rp[i] <= '0;
                r_wp[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (save_hit) begin
                r_wp[idx] <= wp_next;
            end
            if (send_hit) begin
                r_rp[idx] <= rp_next;
            end
        end
    end

    mtrb_ram #(
        .DATA_W (mtrb_pkg::BYTE_W),
        .DEPTH  (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && save_hit),
        .i_re    (i_cmd.exec && send_hit),
        .i_addr  (mem_addr),
        .i_wdata (r_data),
        .o_rdata (mem_rdata)
    );

    // A successful send fills the result slot from RAM data, in S_RDWAIT after the RAM read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !send_hit) || i_cmd.load_read) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !send_hit) begin
            r_out_status <= eval_status;
            r_out_txv    <= 1'b0;
            r_out_byte   <= '0;
        end else if (i_cmd.load_read) begin
            r_out_status <= mtrb_pkg::ST_DONE;
            r_out_txv    <= 1'b1;
            r_out_byte   <= mem_rdata;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_status.send_hit = send_hit;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = {{PAD_W{1'b0}}, r_out_byte, r_out_txv, r_out_status};

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_m_tready))
        else $error("transaction executed while the result slot was occupied");

    a_read_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_read |-> !r_out_valid)
        else $error("queue read data arrived with the result slot still full");

    a_non_send_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !send_hit) |=> (r_out_valid && !r_out_txv))
        else $error("non-send result not presented without a byte");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp[0]} < DEPTH_V) && ({1'b0, r_rp[0]} < DEPTH_V))
        else $error("queue pointer beyond queue depth");

endmodule
`default_nettype wire

// ----- rtl/multichannel_tx_ring_buffer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_tx_ring_buffer_unit
// Per-channel circular transmit byte queues with save and send transactions.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction is latched in the item register, then
// evaluated once the result slot is free; a save or a rejected transaction
// registers its result at evaluation, a successful send after the RAM read.
// A new transaction is accepted only once the controller is back in S_IDLE.
// Reset: synchronous, clears the pointers and the result slot, not the queue RAM.
module multichannel_tx_ring_buffer_unit #(
    parameter int QUEUE_DEPTH  = 256,
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] data_byte, [8] clear_to_send, [9] rx_fifo_empty, [10] tx_fifo_full
    input  wire logic [mtrb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] action, [2:1] channel
    input  wire logic [mtrb_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] status, [3] tx_valid, [11:4] tx_byte
    output logic [mtrb_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    mtrb_pkg::t_ctrl_cmd  cmd;
    mtrb_pkg::t_dp_status dp_status;

    mtrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    mtrb_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .i_cmd      (cmd),
        .o_status   (dp_status),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel transmit ring buffer. A short
// table of directed transactions covers reset, bad channels, the clear-to-send
// and FIFO flag checks and both byte extremes. It is followed by random save
// and send bursts, one complete fill and drain of a queue, and noise. Typed
// rows are checked against the table, the rest against a queue-level predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = 256;
    localparam int NCHAN       = 2;
    localparam int TOTAL_ITEMS = 850;
    localparam int QUIET_TAIL  = 100;
    localparam int STALL_LIMIT = 5000;
    localparam logic [2:0] FLAGS_CLEAN = 3'b110;  // {cts, rxfe, txff}

    typedef struct packed {
        logic                        action;
        logic [mtrb_pkg::CHAN_W-1:0] chan;
        logic [mtrb_pkg::BYTE_W-1:0] data;
        logic                        cts;
        logic                        rxfe;
        logic                        txff;
    } t_uart_req;

    typedef struct packed {
        mtrb_pkg::t_status           status;
        logic                        tx_valid;
        logic [mtrb_pkg::BYTE_W-1:0] tx_byte;
    } t_uart_resp;

    typedef struct {
        t_uart_req  req;
        bit         typed;
        t_uart_resp want;
    } t_plan_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [mtrb_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [mtrb_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mtrb_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: one circular queue per channel.
    logic [mtrb_pkg::BYTE_W-1:0] qmem [NCHAN][DEPTH];
    int                          rd_ptr [NCHAN];
    int                          wr_ptr [NCHAN];

    t_uart_resp resp_fifo [$];
    int         errors = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    multichannel_tx_ring_buffer_unit #(
        .QUEUE_DEPTH  (DEPTH),
        .NUM_CHANNELS (NCHAN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_uart_resp step_queues(t_uart_req r);
        t_uart_resp res;
        int ch;
        int nxt;
        res.status   = mtrb_pkg::ST_DONE;
        res.tx_valid = 1'b0;
        res.tx_byte  = '0;
        ch = int'(r.chan);
        if (ch >= NCHAN) begin
            res.status = mtrb_pkg::ST_BADCHAN;
        end else if (r.action == mtrb_pkg::ACT_SAVE) begin
            nxt = (wr_ptr[ch] + 1) % DEPTH;
            if (nxt == rd_ptr[ch]) begin
                res.status = mtrb_pkg::ST_FULL;
            end else begin
                qmem[ch][wr_ptr[ch]] = r.data;
                wr_ptr[ch] = nxt;
            end
        end else if (rd_ptr[ch] == wr_ptr[ch]) begin
            res.status = mtrb_pkg::ST_EMPTY;
        end else if (ch == 0 && (!r.cts || !r.rxfe)) begin
            // Only the first UART has modem and receive flags to honor.
            res.status = mtrb_pkg::ST_NOTCLEAR;
        end else if (r.txff) begin
            res.status = mtrb_pkg::ST_TXFULL;
        end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = qmem[ch][rd_ptr[ch]];
            rd_ptr[ch] = (rd_ptr[ch] + 1) % DEPTH;
        end
        return res;
    endfunction

    function automatic t_uart_req make_req(logic act, logic [mtrb_pkg::CHAN_W-1:0] ch,
                                           bit clean);
        t_uart_req r;
        logic [2:0] flags;
        flags = clean ? FLAGS_CLEAN : 3'($urandom_range(0, 7));
        r.action = act;
        r.chan   = ch;
        r.data   = 8'($urandom_range(0, 255));
        {r.cts, r.rxfe, r.txff} = flags;
        return r;
    endfunction

    function automatic t_plan_row row(logic act, logic [mtrb_pkg::CHAN_W-1:0] ch,
                                      logic [7:0] d, logic [2:0] flags, bit typed,
                                      mtrb_pkg::t_status st, logic v, logic [7:0] b);
        t_plan_row p;
        p.req.action = act;
        p.req.chan   = ch;
        p.req.data   = d;
        {p.req.cts, p.req.rxfe, p.req.txff} = flags;
        p.typed         = typed;
        p.want.status   = st;
        p.want.tx_valid = v;
        p.want.tx_byte  = b;
        return p;
    endfunction

    // Offers one transaction, optionally after a random gap, and books its
    // expected result once it is accepted.
    task automatic push_item(t_uart_req r, bit typed, t_uart_resp want);
        t_uart_resp model;
        quiet = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mtrb_pkg::S_TDATA_W-11){1'b0}}, r.txff, r.rxfe, r.cts, r.data};
        s_axis_tuser  <= {r.chan, r.action};
        do @(posedge i_clk); while (!s_axis_tready);
        model = step_queues(r);
        resp_fifo.push_back(typed ? want : model);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (resp_fifo.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: random stall bursts of random length, none near the end.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_uart_resp got;
        t_uart_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status   = mtrb_pkg::t_status'(m_axis_tdata[2:0]);
            got.tx_valid = m_axis_tdata[3];
            got.tx_byte  = m_axis_tdata[11:4];
            if (resp_fifo.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = resp_fifo.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.tx_valid !== want.tx_valid) begin
                    $display("%0t: tx_valid expected %0d actual %0d",
                             $time, want.tx_valid, got.tx_valid);
                    errors++;
                end
                if (got.tx_byte !== want.tx_byte) begin
                    $display("%0t: tx_byte expected %h actual %h",
                             $time, want.tx_byte, got.tx_byte);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_plan_row                   plan [$];
        logic [mtrb_pkg::CHAN_W-1:0] ch;
        int                          mode;
        int                          len;
        bit                          filled;

        filled = 1'b0;
        for (int c = 0; c < NCHAN; c++) begin
            rd_ptr[c] = 0;
            wr_ptr[c] = 0;
        end

        // Flags column is {clear_to_send, rx_fifo_empty, tx_fifo_full}.
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b110, 1'b1,
                           mtrb_pkg::ST_EMPTY,    1'b0, 8'h00));
        // An empty queue reports empty without looking at the UART flags.
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd1, 8'h3C, 3'b001, 1'b1,
                           mtrb_pkg::ST_EMPTY,    1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd2, 8'hAA, 3'b110, 1'b1,
                           mtrb_pkg::ST_BADCHAN,  1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd3, 8'h55, 3'b111, 1'b1,
                           mtrb_pkg::ST_BADCHAN,  1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd0, 8'hFF, 3'b000, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd0, 8'h00, 3'b111, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b010, 1'b1,
                           mtrb_pkg::ST_NOTCLEAR, 1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b100, 1'b1,
                           mtrb_pkg::ST_NOTCLEAR, 1'b0, 8'h00));
        // Not-clear wins over a full transmit FIFO.
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b011, 1'b1,
                           mtrb_pkg::ST_NOTCLEAR, 1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b111, 1'b1,
                           mtrb_pkg::ST_TXFULL,   1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b110, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b1, 8'hFF));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b110, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b1, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b110, 1'b1,
                           mtrb_pkg::ST_EMPTY,    1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd1, 8'h5A, 3'b000, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        // The second channel ignores clear-to-send and the receive flag.
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd1, 8'h00, 3'b000, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b1, 8'h5A));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd1, 8'hA5, 3'b110, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd1, 8'h00, 3'b111, 1'b1,
                           mtrb_pkg::ST_TXFULL,   1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd1, 8'h00, 3'b000, 1'b1,
                           mtrb_pkg::ST_DONE,     1'b1, 8'hA5));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd0, 8'h81, 3'b101, 1'b0,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd1, 8'h7E, 3'b010, 1'b0,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SAVE, 2'd3, 8'hC3, 3'b110, 1'b0,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd1, 8'h00, 3'b001, 1'b0,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));
        plan.push_back(row(mtrb_pkg::ACT_SEND, 2'd0, 8'h00, 3'b110, 1'b0,
                           mtrb_pkg::ST_DONE,     1'b0, 8'h00));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) push_item(plan[i].req, plan[i].typed, plan[i].want);

        while (items_sent < TOTAL_ITEMS) begin
            if (!filled && items_sent >= 250) begin
                // Fill one queue past full, then offer more sends than it holds. This
                // also carries both pointers across the wrap.
                filled = 1'b1;
                drain_results();
                ch = 2'($urandom_range(0, 1));
                repeat (DEPTH + 2)
                    push_item(make_req(mtrb_pkg::ACT_SAVE, ch, 1'b1), 1'b0, '0);
                repeat (DEPTH + 3)
                    push_item(make_req(mtrb_pkg::ACT_SEND, ch, $urandom_range(0, 9) != 0),
                              1'b0, '0);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 16);
                ch   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                   : 2'($urandom_range(0, 1));
                case (mode)
                    0: begin
                        push_item(make_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                           1'($urandom_range(0, 1))), 1'b0, '0);
                    end
                    1: begin
                        repeat (len)
                            push_item(make_req(mtrb_pkg::ACT_SAVE, ch, 1'b1), 1'b0, '0);
                    end
                    2: begin
                        repeat (len)
                            push_item(make_req(mtrb_pkg::ACT_SEND, ch,
                                               $urandom_range(0, 6) != 0), 1'b0, '0);
                    end
                    default: begin
                        repeat (len)
                            push_item(make_req(1'($urandom_range(0, 1)),
                                               2'($urandom_range(0, 1)),
                                               $urandom_range(0, 6) != 0), 1'b0, '0);
                    end
                endcase
            end
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
